// ----- rtl/mmpd_pkg.sv -----
// ----------------------------------------------------------------------------
// mmpd_pkg
// Shared constants and types for the min/max peak decimator.
// ----------------------------------------------------------------------------
package mmpd_pkg;

  localparam int POS_BITS            = 32;
  localparam int CFG_DATA_BITS       = 32;
  localparam int WLOG_BITS           = 4;
  localparam int SAMPLE_BITS_DEF     = 16;
  localparam int MAX_WINDOW_LOG2_DEF = 15;
  localparam int REC_QUEUE_DEPTH     = 2;

  localparam logic [WLOG_BITS-1:0] WINDOW_LOG2_RST = WLOG_BITS'(2);
  localparam logic [POS_BITS-1:0]  HALF_SPAN_RST   = '0;

  typedef enum logic [0:0] {
    CFG_WINDOW_LOG2 = 1'b0,
    CFG_HALF_SPAN   = 1'b1
  } cfg_reg_t;

  // status of the window record queue
  typedef struct packed {
    logic full;
    logic empty;
  } rq_status_t;

endpackage

// ----- rtl/mmpd_front.sv -----
// ----------------------------------------------------------------------------
// mmpd_front
// Tracks min/max and their first offsets per window; builds a window record
// when the window completes.
// ----------------------------------------------------------------------------
module mmpd_front #(
  parameter int SAMPLE_BITS     = mmpd_pkg::SAMPLE_BITS_DEF,
  parameter int MAX_WINDOW_LOG2 = mmpd_pkg::MAX_WINDOW_LOG2_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                take,
  input  logic [mmpd_pkg::POS_BITS-1:0]       sample_x,
  input  logic signed [SAMPLE_BITS-1:0]       sample_y,
  input  logic [mmpd_pkg::WLOG_BITS-1:0]      window_log2,
  input  logic [mmpd_pkg::POS_BITS-1:0]       half_window_span,
  output logic                                rec_push,
  output logic [2*mmpd_pkg::POS_BITS+2*SAMPLE_BITS-1:0] rec_data
);

  localparam int OFS_W = MAX_WINDOW_LOG2 + 1;
  localparam int CNT_W = MAX_WINDOW_LOG2 + 2;
  localparam int LG_W  = $clog2(MAX_WINDOW_LOG2 + 2);

  logic [OFS_W-1:0]               sample_count;
  logic signed [SAMPLE_BITS-1:0]  running_max;
  logic signed [SAMPLE_BITS-1:0]  running_min;
  logic [OFS_W-1:0]               max_offset;
  logic [OFS_W-1:0]               min_offset;
  logic [mmpd_pkg::POS_BITS-1:0]  window_start_x;

  logic signed [SAMPLE_BITS-1:0]  max_next;
  logic signed [SAMPLE_BITS-1:0]  min_next;
  logic [OFS_W-1:0]               max_offset_next;
  logic [OFS_W-1:0]               min_offset_next;
  logic [mmpd_pkg::POS_BITS-1:0]  start_next;
  logic [OFS_W-1:0]               count_next;

  logic [LG_W-1:0]                shift_amt;
  logic [CNT_W-1:0]               win_len;
  logic [CNT_W-1:0]               count_inc;
  logic                           done;
  logic                           min_first;
  logic                           max_later;
  logic signed [SAMPLE_BITS-1:0]  first_y;
  logic signed [SAMPLE_BITS-1:0]  second_y;
  logic [mmpd_pkg::POS_BITS-1:0]  second_x;

  // window log saturates at the largest supported length
  always_comb begin
    if (int'(window_log2) > MAX_WINDOW_LOG2) begin
      shift_amt = LG_W'(MAX_WINDOW_LOG2 + 1);
    end else begin
      shift_amt = LG_W'(window_log2) + LG_W'(1);
    end
    win_len = CNT_W'(1) << shift_amt;
  end

  always_comb begin
    if (sample_count == '0) begin
      start_next      = sample_x;
      max_next        = sample_y;
      min_next        = sample_y;
      max_offset_next = '0;
      min_offset_next = '0;
    end else begin
      start_next      = window_start_x;
      max_next        = running_max;
      min_next        = running_min;
      max_offset_next = max_offset;
      min_offset_next = min_offset;
      if (sample_y > running_max) begin
        max_next        = sample_y;
        max_offset_next = sample_count;
      end
      if (sample_y < running_min) begin
        min_next        = sample_y;
        min_offset_next = sample_count;
      end
    end
    count_inc  = {1'b0, sample_count} + CNT_W'(1);
    done       = (count_inc >= win_len);
    count_next = done ? '0 : count_inc[OFS_W-1:0];

    // equal offsets fall through to the max on both points
    min_first = (min_offset_next < max_offset_next);
    max_later = (min_offset_next > max_offset_next);
    first_y   = min_first ? min_next : max_next;
    second_y  = max_later ? min_next : max_next;
    second_x  = start_next + half_window_span;
  end

  assign rec_push = take && done;
  assign rec_data = {start_next, second_x, first_y, second_y};

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count   <= '0;
      running_max    <= '0;
      running_min    <= '0;
      max_offset     <= '0;
      min_offset     <= '0;
      window_start_x <= '0;
    end else if (take) begin
      sample_count   <= count_next;
      running_max    <= max_next;
      running_min    <= min_next;
      max_offset     <= max_offset_next;
      min_offset     <= min_offset_next;
      window_start_x <= start_next;
    end
  end

endmodule

// ----- rtl/mmpd_rec_fifo.sv -----
// ----------------------------------------------------------------------------
// mmpd_rec_fifo
// Short queue of completed window records between front and back.
// ----------------------------------------------------------------------------
module mmpd_rec_fifo #(
  parameter int WIDTH = 2 * mmpd_pkg::POS_BITS + 2 * mmpd_pkg::SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   wr_en,
  input  logic [WIDTH-1:0]       wr_data,
  input  logic                   rd_en,
  output logic [WIDTH-1:0]       rd_data,
  output mmpd_pkg::rq_status_t   status
);

  localparam int DEPTH = mmpd_pkg::REC_QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;

  logic do_wr;
  logic do_rd;

  assign status.full  = (fill == CNT_W'(DEPTH));
  assign status.empty = (fill == '0);
  assign do_wr   = wr_en && !status.full;
  assign do_rd   = rd_en && !status.empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({do_wr, do_rd})
        2'b10:   fill <= fill + CNT_W'(1);
        2'b01:   fill <= fill - CNT_W'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ----- rtl/mmpd_back.sv -----
// ----------------------------------------------------------------------------
// mmpd_back
// Output register: turns each window record into its two points.
// ----------------------------------------------------------------------------
module mmpd_back #(
  parameter int SAMPLE_BITS = mmpd_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  mmpd_pkg::rq_status_t                rq_status,
  input  logic [2*mmpd_pkg::POS_BITS+2*SAMPLE_BITS-1:0] rq_data,
  output logic                                rq_pop,
  input  logic                                pop,
  output logic                                empty,
  output logic [mmpd_pkg::POS_BITS-1:0]       point_x,
  output logic signed [SAMPLE_BITS-1:0]       point_y,
  output logic                                last_of_pair
);

  localparam int PB = mmpd_pkg::POS_BITS;

  logic                   cur_valid;
  logic                   phase;
  logic [PB-1:0]          cur_start_x;
  logic [PB-1:0]          cur_second_x;
  logic [SAMPLE_BITS-1:0] cur_first_y;
  logic [SAMPLE_BITS-1:0] cur_second_y;

  logic out_xfer;
  logic retire;

  assign out_xfer = pop && cur_valid;
  assign retire   = !cur_valid || (out_xfer && phase);
  assign rq_pop   = retire && !rq_status.empty;

  assign empty        = !cur_valid;
  assign last_of_pair = phase;
  assign point_x      = phase ? cur_second_x : cur_start_x;
  assign point_y      = $signed(phase ? cur_second_y : cur_first_y);

  always_ff @(posedge clk) begin
    if (rq_pop) begin
      {cur_start_x, cur_second_x, cur_first_y, cur_second_y} <= rq_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      phase     <= 1'b0;
    end else if (retire) begin
      cur_valid <= !rq_status.empty;
      phase     <= 1'b0;
    end else if (out_xfer) begin
      phase <= 1'b1;
    end
  end

endmodule

// ----- rtl/minmax_peak_decimator.sv -----
// ----------------------------------------------------------------------------
// minmax_peak_decimator
// Min/max peak-detect decimation of a (position, sample) stream.
// ----------------------------------------------------------------------------
// Takes one sample per cycle while full is low. Every window of 2^(window_log2+1)
// samples yields two points, the earlier extreme at the window start and the
// later one at start + half_window_span; the pair leaves over two pops from
// the output register. The front folds each sample into the running min/max
// in the cycle it is taken; completed windows wait in a two-entry record
// queue, and full rises only while that queue holds two unread windows.
// A partial window emits nothing. Registers are written over the cfg port,
// which is always ready.
module minmax_peak_decimator #(
  parameter int SAMPLE_BITS     = mmpd_pkg::SAMPLE_BITS_DEF,
  parameter int MAX_WINDOW_LOG2 = mmpd_pkg::MAX_WINDOW_LOG2_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   push,
  output logic                                   full,
  input  logic [mmpd_pkg::POS_BITS-1:0]          sample_x,
  input  logic signed [SAMPLE_BITS-1:0]          sample_y,
  input  logic                                   pop,
  output logic                                   empty,
  output logic [mmpd_pkg::POS_BITS-1:0]          point_x,
  output logic signed [SAMPLE_BITS-1:0]          point_y,
  output logic                                   last_of_pair,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [0:0]                             cfg_index,
  input  logic [mmpd_pkg::CFG_DATA_BITS-1:0]     cfg_data
);

  localparam int REC_W = 2 * mmpd_pkg::POS_BITS + 2 * SAMPLE_BITS;

  logic [mmpd_pkg::WLOG_BITS-1:0] window_log2;
  logic [mmpd_pkg::POS_BITS-1:0]  half_window_span;

  logic                 take;
  logic                 rec_push;
  logic [REC_W-1:0]     rec_data;
  logic                 rq_pop;
  logic [REC_W-1:0]     rq_data;
  mmpd_pkg::rq_status_t rq_status;

  assign cfg_ready = 1'b1;
  assign full      = rq_status.full;
  assign take      = push && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_log2      <= mmpd_pkg::WINDOW_LOG2_RST;
      half_window_span <= mmpd_pkg::HALF_SPAN_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        mmpd_pkg::CFG_WINDOW_LOG2: window_log2      <= cfg_data[mmpd_pkg::WLOG_BITS-1:0];
        mmpd_pkg::CFG_HALF_SPAN:   half_window_span <= cfg_data[mmpd_pkg::POS_BITS-1:0];
        default: ;
      endcase
    end
  end

  mmpd_front #(
    .SAMPLE_BITS     (SAMPLE_BITS),
    .MAX_WINDOW_LOG2 (MAX_WINDOW_LOG2)
  ) u_front (
    .clk              (clk),
    .rst              (rst),
    .take             (take),
    .sample_x         (sample_x),
    .sample_y         (sample_y),
    .window_log2      (window_log2),
    .half_window_span (half_window_span),
    .rec_push         (rec_push),
    .rec_data         (rec_data)
  );

  mmpd_rec_fifo #(
    .WIDTH (REC_W)
  ) u_rec_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (rec_push),
    .wr_data (rec_data),
    .rd_en   (rq_pop),
    .rd_data (rq_data),
    .status  (rq_status)
  );

  mmpd_back #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .rq_status    (rq_status),
    .rq_data      (rq_data),
    .rq_pop       (rq_pop),
    .pop          (pop),
    .empty        (empty),
    .point_x      (point_x),
    .point_y      (point_y),
    .last_of_pair (last_of_pair)
  );

endmodule
